>>> hw/rtl/olkd_pkg.sv
// Package for the ordered list with key delete.
// Holds the operation and status codes, the transfer structs and the cell command struct.
// No dependencies.
package olkd_pkg;

  localparam int unsigned KindBits   = 3;
  localparam int unsigned FieldBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 5;

  typedef enum logic [KindBits-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_REM_HEAD = 3'd2,
    KIND_REM_TAIL = 3'd3,
    KIND_FIND     = 3'd4,
    KIND_REM_KEY  = 3'd5
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [FieldBits-1:0] value;
  } in_t;

  typedef struct packed {
    logic [FieldBits-1:0]  word;
    logic [StatusBits-1:0] status;
    logic [CountBits-1:0]  count;
  } out_t;

  typedef struct packed {
    logic ins_head;
    logic ins_tail;
    logic rem_head;
    logic rem_key;
    logic pick_head;
    logic pick_last;
    logic pick_first;
  } cell_cmd_t;

endpackage

>>> hw/rtl/olkd_cell.sv
// One position of the ordered list: holds an entry, compares it with the key and shifts.
// Depends on olkd_pkg for the cell command struct.
module olkd_cell #(
  parameter int unsigned Idx      = 0,
  parameter int unsigned WordBits = 32,
  parameter int unsigned CntW     = 5
) (
  input  logic                 clk_i,
  input  olkd_pkg::cell_cmd_t  cmd_i,
  input  logic [CntW-1:0]      cnt_i,
  input  logic [WordBits-1:0]  value_i,
  input  logic [WordBits-1:0]  mask_i,
  input  logic [WordBits-1:0]  left_i,
  input  logic [WordBits-1:0]  right_i,
  input  logic                 seen_i,
  output logic [WordBits-1:0]  entry_o,
  output logic                 seen_o,
  output logic [WordBits-1:0]  pick_o
);
  import olkd_pkg::*;

  logic [WordBits-1:0] entry_q, entry_d;
  logic                valid, hit, first, last, sel;

  assign valid  = cnt_i > CntW'(Idx);
  assign last   = cnt_i == CntW'(Idx + 1);
  assign hit    = valid && (((entry_q ^ value_i) & mask_i) == '0);
  assign first  = hit && !seen_i;
  assign seen_o = seen_i || hit;

  assign sel = (cmd_i.pick_head && (Idx == 0)) || (cmd_i.pick_last && last) ||
               (cmd_i.pick_first && first);
  assign pick_o  = sel ? entry_q : '0;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_head) begin
      entry_d = (Idx == 0) ? value_i : left_i;
    end else if (cmd_i.ins_tail) begin
      if (cnt_i == CntW'(Idx)) begin
        entry_d = value_i;
      end
    end else if (cmd_i.rem_head) begin
      entry_d = right_i;
    end else if (cmd_i.rem_key && seen_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> hw/rtl/ordered_list_with_key_delete.sv
// Top level of the ordered list with key delete: a chain of list cells plus the count,
// the mask register and the result register. Depends on olkd_pkg and olkd_cell.
//
//   Channel   Signals                         Transfer when
//   op        start_i, busy_o, op_i           start_i high and busy_o low
//   result    res_valid_o, res_o              res_valid_o high (one cycle)
//   mask      mask_we_i, mask_wdata_i         mask_we_i high
//
// Each operation is applied to the cell chain at the transfer; its result is registered and appears in the cycle after
// the transfer, so an operation can be taken every cycle and busy_o stays low.
// The key search ripples a found flag from the head cell to the tail cell.
// Reset clears the count and the result strobe and sets the mask to all ones.
// The receiver cannot stall the result.
module ordered_list_with_key_delete #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  olkd_pkg::in_t        op_i,
  input  logic                 mask_we_i,
  input  logic [31:0]          mask_wdata_i,
  output logic                 res_valid_o,
  output olkd_pkg::out_t       res_o
);
  import olkd_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [31:0]           mask_q;
  logic                  done_q;
  out_t                  res_q, res_d;
  logic [StatusBits-1:0] status_d;
  cell_cmd_t             cmd;
  logic                  take, full, empty, found;
  logic [WORD_BITS-1:0]  value, mask, picked;
  logic [WORD_BITS-1:0]  ent  [DEPTH];
  logic [WORD_BITS-1:0]  pick [DEPTH];
  logic                  seen [DEPTH+1];

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;
  assign full   = cnt_q == CntW'(DEPTH);
  assign empty  = cnt_q == '0;
  assign value  = WORD_BITS'(op_i.value);
  assign mask   = WORD_BITS'(mask_q);
  assign seen[0] = 1'b0;
  assign found  = seen[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (g == 0) begin : g_l0
      assign left = ent[g];
    end else begin : g_l
      assign left = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_rn
      assign right = ent[g];
    end else begin : g_r
      assign right = ent[g+1];
    end
    olkd_cell #(.Idx(g), .WordBits(WORD_BITS), .CntW(CntW)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .cnt_i   (cnt_q),
      .value_i (value),
      .mask_i  (mask),
      .left_i  (left),
      .right_i (right),
      .seen_i  (seen[g]),
      .entry_o (ent[g]),
      .seen_o  (seen[g+1]),
      .pick_o  (pick[g])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | pick[i];
    end
  end

  always_comb begin
    cmd      = '0;
    cnt_d    = cnt_q;
    status_d = STATUS_OK;
    case (kind_e'(op_i.kind))
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          cmd.ins_head = take && (op_i.kind == KIND_INS_HEAD);
          cmd.ins_tail = take && (op_i.kind == KIND_INS_TAIL);
          cnt_d        = cnt_q + 1'b1;
        end
      end
      KIND_REM_HEAD, KIND_REM_TAIL: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          cmd.rem_head  = take && (op_i.kind == KIND_REM_HEAD);
          cmd.pick_head = op_i.kind == KIND_REM_HEAD;
          cmd.pick_last = op_i.kind == KIND_REM_TAIL;
          cnt_d         = cnt_q - 1'b1;
        end
      end
      KIND_FIND, KIND_REM_KEY: begin
        cmd.pick_first = 1'b1;
        if (!found) begin
          status_d = STATUS_EMPTY;
        end else if (op_i.kind == KIND_REM_KEY) begin
          cmd.rem_key = take;
          cnt_d       = cnt_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_d = '{word: 32'(picked), status: status_d, count: CountBits'(32'(cnt_d))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mask_q <= '1;
      done_q <= 1'b0;
    end else begin
      done_q <= take;
      if (take) begin
        cnt_q <= cnt_d;
      end
      if (mask_we_i) begin
        mask_q <= mask_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = done_q;
  assign res_o       = res_q;

endmodule

>>> sim/ordered_list_with_key_delete_tb.sv
// Testbench for the ordered list with key delete: directed tests, then random phases.
// Predicts every result from its own copy of the list and mask and checks each transfer.
// Depends on olkd_pkg and ordered_list_with_key_delete.
module ordered_list_with_key_delete_tb;
  import olkd_pkg::*;

  localparam int unsigned ListDepth  = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [KindBits-1:0] KindSpare6 = 3'd6;
  localparam logic [KindBits-1:0] KindSpare7 = 3'd7;
  localparam logic [31:0] MaskAll = 32'hFFFF_FFFF;
  localparam logic [31:0] MaskNone = 32'h0000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  in_t         op_i = '0;
  logic        mask_we_i = 1'b0;
  logic [31:0] mask_wdata_i = '0;
  logic        busy_o;
  logic        res_valid_o;
  out_t        res_o;

  logic [31:0] list_words [ListDepth];
  int unsigned list_len = 0;
  logic [31:0] match_mask = MaskAll;
  out_t        pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  ordered_list_with_key_delete #(
    .DEPTH    (ListDepth),
    .WORD_BITS(32)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .mask_we_i   (mask_we_i),
    .mask_wdata_i(mask_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("Mismatch at cycle %0d: %s is %h, expected %h", cycle_count, what, got, want);
    end
  endtask

  task automatic drop_entry(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < list_len; i++) begin
      list_words[i] = list_words[i + 1];
    end
    list_len--;
  endtask

  task automatic apply_list_op(input in_t op, output out_t res);
    int unsigned i;
    int hit;
    res = '0;
    hit = -1;
    case (op.kind)
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (list_len >= ListDepth) begin
          res.status = STATUS_FULL;
        end else if (op.kind == KIND_INS_HEAD) begin
          for (i = list_len; i > 0; i--) begin
            list_words[i] = list_words[i - 1];
          end
          list_words[0] = op.value;
          list_len++;
        end else begin
          list_words[list_len] = op.value;
          list_len++;
        end
      end
      KIND_REM_HEAD, KIND_REM_TAIL: begin
        if (list_len == 0) begin
          res.status = STATUS_EMPTY;
        end else if (op.kind == KIND_REM_HEAD) begin
          res.word = list_words[0];
          drop_entry(0);
        end else begin
          res.word = list_words[list_len - 1];
          list_len--;
        end
      end
      KIND_FIND, KIND_REM_KEY: begin
        for (i = 0; i < list_len; i++) begin
          if (hit < 0 && ((list_words[i] ^ op.value) & match_mask) == 0) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.word = list_words[hit];
          if (op.kind == KIND_REM_KEY) begin
            drop_entry(hit);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = list_len[CountBits-1:0];
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", res_o.word, '0);
      end else begin
        want = pending_results.pop_front();
        if (res_o.word !== want.word) begin
          report_mismatch("word", res_o.word, want.word);
        end
        if (res_o.status !== want.status) begin
          report_mismatch("status", 32'(res_o.status), 32'(want.status));
        end
        if (res_o.count !== want.count) begin
          report_mismatch("count", 32'(res_o.count), 32'(want.count));
        end
      end
    end
  end

  task automatic issue_op(input logic [KindBits-1:0] kind, input logic [31:0] value);
    in_t  op;
    out_t res;
    op.kind = kind;
    op.value = value;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_list_op(op, res);
    pending_results.push_back(res);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [31:0] mask);
    settle();
    mask_we_i <= 1'b1;
    mask_wdata_i <= mask;
    @(posedge clk_i);
    mask_we_i <= 1'b0;
    match_mask = mask;
  endtask

  task automatic test_empty_list();
    issue_op(KIND_REM_HEAD, 32'h0);
    issue_op(KIND_REM_TAIL, 32'hFFFF_FFFF);
    issue_op(KIND_FIND, 32'h0);
    issue_op(KIND_REM_KEY, 32'hFFFF_FFFF);
    issue_op(KindSpare6, 32'h1234_5678);
    issue_op(KindSpare7, 32'hFFFF_FFFF);
  endtask

  task automatic test_insert_find();
    issue_op(KIND_INS_HEAD, 32'h0000_0000);
    issue_op(KIND_INS_TAIL, 32'hFFFF_FFFF);
    issue_op(KIND_INS_HEAD, 32'h1234_5678);
    issue_op(KIND_INS_TAIL, 32'hA5A5_A5A5);
    issue_op(KIND_FIND, 32'h1234_5678);
    issue_op(KIND_FIND, 32'hDEAD_BEEF);
    issue_op(KIND_REM_KEY, 32'hFFFF_FFFF);
    issue_op(KIND_REM_KEY, 32'hDEAD_BEEF);
    issue_op(KIND_REM_HEAD, 32'h0);
    issue_op(KIND_REM_TAIL, 32'h0);
    issue_op(KindSpare7, 32'h0);
  endtask

  task automatic test_full_list();
    while (list_len < ListDepth) begin
      issue_op(KIND_INS_TAIL, $urandom);
    end
    issue_op(KIND_INS_HEAD, 32'h5A5A_5A5A);
    issue_op(KIND_INS_TAIL, 32'hFFFF_FFFF);
    issue_op(KIND_FIND, list_words[ListDepth - 1]);
    issue_op(KIND_REM_KEY, list_words[ListDepth - 1]);
  endtask

  task automatic test_key_mask();
    write_mask(32'h0000_FFFF);
    issue_op(KIND_FIND, list_words[3] ^ 32'hABCD_0000);
    issue_op(KIND_REM_KEY, list_words[5] ^ 32'h8000_0000);
    write_mask(MaskNone);
    issue_op(KIND_FIND, $urandom);
    issue_op(KIND_REM_KEY, $urandom);
  endtask

  task automatic run_random_phase(input int unsigned n_items, input logic [31:0] mask,
                                  input int unsigned idle_pct, input int unsigned fill_pct);
    int unsigned roll;
    logic [31:0] value;
    write_mask(mask);
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        issue_op($urandom_range(1) ? KindSpare6 : KindSpare7, $urandom);
      end else if (roll < 4 + fill_pct) begin
        value = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom;
        issue_op($urandom_range(1) ? KIND_INS_HEAD : KIND_INS_TAIL, value);
      end else begin
        if (list_len > 0 && $urandom_range(3) != 0) begin
          value = list_words[$urandom_range(list_len - 1)];
          value = (value & match_mask) | ($urandom & ~match_mask);
        end else begin
          value = $urandom;
        end
        case ($urandom_range(3))
          0: issue_op(KIND_REM_HEAD, value);
          1: issue_op(KIND_REM_TAIL, value);
          2: issue_op(KIND_FIND, value);
          default: issue_op(KIND_REM_KEY, value);
        endcase
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_insert_find();
    test_full_list();
    test_key_mask();
    run_random_phase(230, MaskAll, 0, 50);
    run_random_phase(230, MaskNone, 48, 45);
    run_random_phase(230, 32'h0000_00FF, 20, 55);
    run_random_phase(230, $urandom, 48, 50);
    run_random_phase(230, $urandom, 0, 65);
    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/olkd_pkg.sv
hw/rtl/olkd_cell.sv
hw/rtl/ordered_list_with_key_delete.sv
sim/ordered_list_with_key_delete_tb.sv
